// ===== rtl/debounced_rotary_encoder_button_assert.svh =====
// Assertion macros for the encoder and button RTL top level.
`ifndef DEBOUNCED_ROTARY_ENCODER_BUTTON_ASSERT_SVH
`define DEBOUNCED_ROTARY_ENCODER_BUTTON_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define DREBTN_ASSERT_SAME(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("assertion failed in debounced_rotary_encoder_button");

// The condition holds in the cycle after the trigger.
`define DREBTN_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("assertion failed in debounced_rotary_encoder_button");

`endif

// ===== rtl/drebtn_pkg.sv =====
// Types and constants for the debounced rotary encoder and button block.
package drebtn_pkg;

	// Action queued by a falling edge and committed after release.
	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_BUTTON = 2'd1,
		ACT_DEC    = 2'd2,
		ACT_INC    = 2'd3
	} action_t;

	localparam int unsigned TICKS_W = 8;
	localparam logic [TICKS_W-1:0] RELEASE_TICKS_RST = 8'd3;
	localparam logic [TICKS_W-1:0] RELEASE_CNT_MAX = 8'hFF;
	localparam logic [2:0] LEVELS_RELEASED = 3'b111;

	// Bit positions of the three lines in a level sample.
	localparam int unsigned LVL_BUTTON = 0;
	localparam int unsigned LVL_LINE_A = 1;
	localparam int unsigned LVL_LINE_B = 2;

	// Debounce control state, apart from the detent count.
	typedef struct packed {
		logic [2:0]         levels;
		action_t            pending;
		logic [TICKS_W-1:0] rel_cnt;
		logic               press;
	} ctrl_state_t;

endpackage

// ===== rtl/debounced_rotary_encoder_button.sv =====
// Top level of the debounced rotary encoder and push button block.
// A result is valid in the cycle after its input transfer.
// One item per cycle unless out_ready stalls; state update is one register step.
// A new item transfers in the same cycle as the waiting result is taken.
// Reset (arst_n low) releases all lines, clears the queue, count and flag,
// and sets release_ticks to 3.
`include "debounced_rotary_encoder_button_assert.svh"

module debounced_rotary_encoder_button import drebtn_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               button_level,
	input  logic               line_a_level,
	input  logic               line_b_level,
	input  logic               tick,
	input  logic               take_count,
	input  logic               take_press,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] count_value,
	output logic               pressed,
	output logic               activity,
	output logic [1:0]         pending_action
);

	logic [TICKS_W-1:0]            release_ticks_q;
	ctrl_state_t                   state_q;
	logic signed [COUNT_WIDTH-1:0] count_q;
	ctrl_state_t                   state_nxt;
	logic signed [COUNT_WIDTH-1:0] count_nxt;
	logic signed [COUNT_WIDTH-1:0] res_count;
	logic                          res_press;
	action_t                       res_pending;
	logic                          out_valid_q;
	logic                          in_xfer;
	logic [2:0]                    levels;

	assign levels   = {line_b_level, line_a_level, button_level};
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_ticks_q <= RELEASE_TICKS_RST;
		end else if (cfg_we) begin
			release_ticks_q <= cfg_wdata;
		end
	end

	drebtn_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.cur          (state_q),
		.cur_count    (count_q),
		.levels       (levels),
		.tick         (tick),
		.take_count   (take_count),
		.take_press   (take_press),
		.release_ticks(release_ticks_q),
		.nxt          (state_nxt),
		.nxt_count    (count_nxt),
		.res_count    (res_count),
		.res_press    (res_press),
		.res_pending  (res_pending)
	);

	// Debounce state advances on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.levels  <= LEVELS_RELEASED;
			state_q.pending <= ACT_NONE;
			state_q.rel_cnt <= '0;
			state_q.press   <= 1'b0;
			count_q         <= '0;
		end else if (in_xfer) begin
			state_q <= state_nxt;
			count_q <= count_nxt;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; the count reports its low 16 bits, sign-extended when narrower.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			count_value    <= 16'(res_count);
			pressed        <= res_press;
			activity       <= res_press || (res_count != '0);
			pending_action <= res_pending;
		end
	end

	// Checks on the result register and the debounce state.
	`DREBTN_ASSERT_SAME(a_ready_when_empty, !out_valid_q, in_ready)
	`DREBTN_ASSERT_NEXT(a_result_follows_input, in_xfer, out_valid)
	`DREBTN_ASSERT_NEXT(a_drained_goes_empty, out_valid_q && out_ready && !in_xfer, !out_valid)
	`DREBTN_ASSERT_SAME(a_idle_counter_clear, state_q.pending == ACT_NONE, state_q.rel_cnt == '0)

endmodule

// ===== rtl/drebtn_step.sv =====
// Next-state and result logic for one sample of the encoder and button lines.
module drebtn_step import drebtn_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  ctrl_state_t                    cur,
	input  logic signed [COUNT_WIDTH-1:0]  cur_count,
	input  logic [2:0]                     levels,
	input  logic                           tick,
	input  logic                           take_count,
	input  logic                           take_press,
	input  logic [TICKS_W-1:0]             release_ticks,
	output ctrl_state_t                    nxt,
	output logic signed [COUNT_WIDTH-1:0]  nxt_count,
	output logic signed [COUNT_WIDTH-1:0]  res_count,
	output logic                           res_press,
	output action_t                        res_pending
);

	localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	logic [2:0]         falls;
	logic [TICKS_W-1:0] need;
	action_t            pend_latched;
	action_t            pend_upd;
	logic [TICKS_W-1:0] cnt_upd;
	logic               press_upd;
	logic signed [COUNT_WIDTH-1:0] count_upd;

	assign falls = cur.levels & ~levels;
	assign need  = (release_ticks == '0) ? TICKS_W'(1) : release_ticks;

	// Latch one edge when nothing is queued, button first, then A, then B.
	always_comb begin
		pend_latched = cur.pending;
		if (cur.pending == ACT_NONE) begin
			if (falls[LVL_BUTTON]) begin
				pend_latched = ACT_BUTTON;
			end else if (falls[LVL_LINE_A]) begin
				pend_latched = ACT_DEC;
			end else if (falls[LVL_LINE_B]) begin
				pend_latched = ACT_INC;
			end
		end
	end

	// Count released ticks and commit the queued action once enough have passed.
	always_comb begin
		pend_upd  = pend_latched;
		cnt_upd   = cur.rel_cnt;
		press_upd = cur.press;
		count_upd = cur_count;
		if (tick) begin
			if (levels == LEVELS_RELEASED && pend_latched != ACT_NONE) begin
				if (cur.rel_cnt != RELEASE_CNT_MAX) begin
					cnt_upd = cur.rel_cnt + TICKS_W'(1);
				end
			end else begin
				cnt_upd = '0;
			end
			if (cnt_upd >= need) begin
				case (pend_latched)
					ACT_BUTTON: press_upd = 1'b1;
					ACT_DEC: begin
						if (cur_count != COUNT_MIN) begin
							count_upd = cur_count - COUNT_WIDTH'(1);
						end
					end
					ACT_INC: begin
						if (cur_count != COUNT_MAX) begin
							count_upd = cur_count + COUNT_WIDTH'(1);
						end
					end
					default: ;
				endcase
				pend_upd = ACT_NONE;
				cnt_upd  = '0;
			end
		end
	end

	// The result shows the state before the take requests clear it.
	assign res_count   = count_upd;
	assign res_press   = press_upd;
	assign res_pending = pend_upd;

	always_comb begin
		nxt.levels  = levels;
		nxt.pending = pend_upd;
		nxt.rel_cnt = cnt_upd;
		nxt.press   = take_press ? 1'b0 : press_upd;
		nxt_count   = take_count ? '0 : count_upd;
	end

endmodule

// ===== dv/detent_report_checker.sv =====
// Checker that predicts and compares the encoder and button reports.
`timescale 1ns / 1ps

module detent_report_checker import drebtn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               button_level,
	input  logic               line_a_level,
	input  logic               line_b_level,
	input  logic               tick,
	input  logic               take_count,
	input  logic               take_press,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] count_value,
	input  logic               pressed,
	input  logic               activity,
	input  logic [1:0]         pending_action,
	output int                 reports_awaited,
	output int                 report_errors
);

	localparam logic signed [15:0] DETENT_MAX = 16'sh7FFF;
	localparam logic signed [15:0] DETENT_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [15:0] detents;
		logic               pressed;
		logic               activity;
		action_t            pending;
	} detent_report_t;

	// Shadow copy of the block state and its one register.
	logic [TICKS_W-1:0] release_need_cfg = RELEASE_TICKS_RST;
	logic [2:0]         last_levels = LEVELS_RELEASED;
	action_t            queued = ACT_NONE;
	logic [TICKS_W-1:0] release_run = '0;
	logic signed [15:0] detents = '0;
	logic               press_held = 1'b0;

	detent_report_t awaited[$];

	// Works out the report for one item and advances the shadow state.
	function automatic detent_report_t predict_detent_report(input logic [2:0] levels,
			input logic tk, input logic clr_count, input logic clr_press);
		logic [2:0]         falls;
		logic [TICKS_W-1:0] need;
		detent_report_t     rpt;
		falls = last_levels & ~levels;
		need = (release_need_cfg == '0) ? 8'd1 : release_need_cfg;

		// Only one action may wait; the button wins, then A, then B.
		if (queued == ACT_NONE) begin
			if (falls[LVL_BUTTON])
				queued = ACT_BUTTON;
			else if (falls[LVL_LINE_A])
				queued = ACT_DEC;
			else if (falls[LVL_LINE_B])
				queued = ACT_INC;
		end
		last_levels = levels;

		// Released ticks build up toward a commit; anything else restarts the run.
		if (tk) begin
			if (levels == LEVELS_RELEASED && queued != ACT_NONE) begin
				if (release_run != RELEASE_CNT_MAX)
					release_run = release_run + 1'b1;
			end else begin
				release_run = '0;
			end
			if (release_run >= need) begin
				case (queued)
					ACT_BUTTON: press_held = 1'b1;
					ACT_DEC: if (detents != DETENT_MIN) detents = detents - 16'sd1;
					ACT_INC: if (detents != DETENT_MAX) detents = detents + 16'sd1;
					default: ;
				endcase
				queued = ACT_NONE;
				release_run = '0;
			end
		end

		rpt.detents = detents;
		rpt.pressed = press_held;
		rpt.activity = press_held || (detents != 0);
		rpt.pending = queued;

		// The take requests clear after the report is formed.
		if (clr_count)
			detents = '0;
		if (clr_press)
			press_held = 1'b0;
		return rpt;
	endfunction

	task automatic check_field(input string field, input int want, input int seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
			report_errors++;
		end
	endtask

	// Compare each result transfer, then predict for each input transfer.
	always @(posedge clk or negedge arst_n) begin
		detent_report_t want;
		if (!arst_n) begin
			release_need_cfg = RELEASE_TICKS_RST;
			last_levels = LEVELS_RELEASED;
			queued = ACT_NONE;
			release_run = '0;
			detents = '0;
			press_held = 1'b0;
			awaited.delete();
			reports_awaited <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					$display("%0t: unexpected result, count_value %0d pressed %0d", $time,
						count_value, pressed);
					report_errors++;
				end else begin
					want = awaited.pop_front();
					check_field("count_value", want.detents, count_value);
					check_field("pressed", want.pressed, pressed);
					check_field("activity", want.activity, activity);
					check_field("pending_action", want.pending, pending_action);
				end
			end
			if (in_valid && in_ready)
				awaited.push_back(predict_detent_report(
					{line_b_level, line_a_level, button_level}, tick, take_count, take_press));
			if (cfg_we)
				release_need_cfg = cfg_wdata;
			reports_awaited <= awaited.size();
		end
	end

endmodule

// ===== dv/debounced_rotary_encoder_button_tb.sv =====
// Testbench top: stimulus, flow control and verdict for the encoder and button block.
`timescale 1ns / 1ps

module debounced_rotary_encoder_button_tb;
	import drebtn_pkg::*;

	// Level samples with all lines released, or with one or more lines held down.
	localparam logic [2:0] LV_UP       = LEVELS_RELEASED;
	localparam logic [2:0] LV_BTN_DOWN = LEVELS_RELEASED & ~(3'b1 << LVL_BUTTON);
	localparam logic [2:0] LV_A_DOWN   = LEVELS_RELEASED & ~(3'b1 << LVL_LINE_A);
	localparam logic [2:0] LV_B_DOWN   = LEVELS_RELEASED & ~(3'b1 << LVL_LINE_B);
	localparam logic [2:0] LV_BTN_A    = LV_BTN_DOWN & LV_A_DOWN;
	localparam logic [2:0] LV_A_B      = LV_A_DOWN & LV_B_DOWN;
	localparam logic [2:0] LV_ALL_DOWN = 3'b000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [7:0]         cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic               button_level;
	logic               line_a_level;
	logic               line_b_level;
	logic               tick;
	logic               take_count;
	logic               take_press;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] count_value;
	logic               pressed;
	logic               activity;
	logic [1:0]         pending_action;
	int                 reports_awaited;
	int                 report_errors;

	int                 send_idle_pct = 0;
	int                 stall_pct = 0;
	int                 items_sent = 0;
	logic [7:0]         ticks_setting = RELEASE_TICKS_RST;

	debounced_rotary_encoder_button dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.button_level   (button_level),
		.line_a_level   (line_a_level),
		.line_b_level   (line_b_level),
		.tick           (tick),
		.take_count     (take_count),
		.take_press     (take_press),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.count_value    (count_value),
		.pressed        (pressed),
		.activity       (activity),
		.pending_action (pending_action)
	);

	detent_report_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.button_level    (button_level),
		.line_a_level    (line_a_level),
		.line_b_level    (line_b_level),
		.tick            (tick),
		.take_count      (take_count),
		.take_press      (take_press),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.count_value     (count_value),
		.pressed         (pressed),
		.activity        (activity),
		.pending_action  (pending_action),
		.reports_awaited (reports_awaited),
		.report_errors   (report_errors)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	// The receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic bit coin(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	// One input transfer, with random idle cycles in front of it.
	task automatic send_item(input logic [2:0] levels, input logic tk, input logic clr_count,
			input logic clr_press);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		button_level <= levels[LVL_BUTTON];
		line_a_level <= levels[LVL_LINE_A];
		line_b_level <= levels[LVL_LINE_B];
		tick <= tk;
		take_count <= clr_count;
		take_press <= clr_press;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Hold the sender off until every expected result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (reports_awaited != 0);
	endtask

	task automatic write_release_ticks(input logic [7:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		ticks_setting = value;
	endtask

	// Mostly a press or turn followed by enough released ticks to commit it;
	// the rest is random noise on all inputs.
	task automatic run_gesture();
		logic [2:0] held;
		int         ticks_left;
		int         bounce_at;
		if (coin(20)) begin
			repeat ($urandom_range(1, 4))
				send_item(3'($urandom_range(7)), 1'($urandom_range(1)), coin(8), coin(8));
		end else begin
			held = LEVELS_RELEASED;
			held[$urandom_range(2)] = 1'b0;
			if (coin(25))
				held[$urandom_range(2)] = 1'b0;
			repeat ($urandom_range(1, 3))
				send_item(coin(15) ? 3'($urandom_range(7)) : held, 1'($urandom_range(1)),
					coin(8), coin(8));
			ticks_left = ((ticks_setting == 0) ? 1 : ticks_setting) + $urandom_range(2);
			bounce_at = coin(10) ? $urandom_range(1, ticks_left) : 0;
			while (ticks_left > 0) begin
				if (ticks_left == bounce_at) begin
					// A bounce on a tick restarts the release run.
					send_item(held, 1'b1, 1'b0, 1'b0);
					bounce_at = 0;
				end else if (coin(15)) begin
					send_item(LV_UP, 1'b0, coin(8), coin(8));
				end else begin
					send_item(LV_UP, 1'b1, coin(8), coin(8));
					ticks_left--;
				end
			end
		end
	endtask

	task automatic run_phase(input logic [7:0] ticks_value, input int idle_pct,
			input int stall, input int n);
		int stop_at;
		write_release_ticks(ticks_value);
		send_idle_pct = idle_pct;
		stall_pct = stall;
		stop_at = items_sent + n;
		while (items_sent < stop_at - n / 2)
			run_gesture();
		drain_results();
		while (items_sent < stop_at)
			run_gesture();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		button_level <= 1'b1;
		line_a_level <= 1'b1;
		line_b_level <= 1'b1;
		tick <= 1'b0;
		take_count <= 1'b0;
		take_press <= 1'b0;
		out_ready <= 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sequence at the reset setting of three release ticks.
		send_item(LV_UP, 1'b0, 1'b0, 1'b0);
		send_item(LV_BTN_DOWN, 1'b1, 1'b0, 1'b0);
		// Another edge while the press waits is ignored.
		send_item(LV_BTN_A, 1'b1, 1'b0, 1'b0);
		send_item(LV_UP, 1'b1, 1'b0, 1'b0);
		send_item(LV_UP, 1'b0, 1'b0, 1'b0);
		send_item(LV_UP, 1'b1, 1'b0, 1'b0);
		send_item(LV_UP, 1'b1, 1'b0, 1'b0);
		// All lines fall together; the button takes priority and commits
		// over a press that is still set, then is taken in the same item.
		send_item(LV_ALL_DOWN, 1'b0, 1'b0, 1'b0);
		repeat (2) send_item(LV_UP, 1'b1, 1'b0, 1'b0);
		send_item(LV_UP, 1'b1, 1'b0, 1'b1);
		send_item(LV_A_DOWN, 1'b0, 1'b0, 1'b0);
		repeat (3) send_item(LV_UP, 1'b1, 1'b0, 1'b0);
		// A and B together queue a decrement; a tick with B low restarts the run.
		send_item(LV_A_B, 1'b0, 1'b0, 1'b0);
		send_item(LV_UP, 1'b1, 1'b0, 1'b0);
		send_item(LV_B_DOWN, 1'b1, 1'b0, 1'b0);
		repeat (3) send_item(LV_UP, 1'b1, 1'b0, 1'b0);
		send_item(LV_B_DOWN, 1'b0, 1'b0, 1'b0);
		repeat (2) send_item(LV_UP, 1'b1, 1'b0, 1'b0);
		send_item(LV_UP, 1'b1, 1'b1, 1'b0);

		// Random phases across settings and flow-control patterns.
		run_phase(8'd1, 0, 0, 150);
		run_phase(8'd0, 86, 0, 150);
		run_phase(8'd2, 0, 86, 150);
		run_phase(8'd5, 26, 26, 150);
		run_phase(8'd255, 0, 0, 400);
		run_phase(8'd3, 26, 26, 100);

		drain_results();
		repeat (4) @(posedge clk);
		if (report_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
